FILE: rtl/core/ipe_pkg.sv
package ipe_pkg;

    // Field widths
    localparam int TIME_W   = 16;
    localparam int GAIN_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Pulse width is scaled down by 128 before the gain multiply
    localparam int WIDTH_SHIFT = 7;
    localparam int SCALED_W    = TIME_W - WIDTH_SHIFT;
    localparam int PROD_W      = GAIN_W + SCALED_W;

    // Stream payload widths (tdata filled up to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MISS = 8'd1;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST        = 8'd0;
    localparam logic [TIME_W-1:0] MISS_WINDOW_RST = 16'd100;
    localparam logic [TIME_W-1:0] TIME_MAX        = 16'hFFFF;

    // Item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    typedef struct packed {
        logic              func;
        logic              edge_rising;
        logic [TIME_W-1:0] capture_time;
        logic [TIME_W-1:0] now_count;
    } item_t;

    typedef struct packed {
        logic              injector_drive;
        logic [TIME_W-1:0] end_time;
        logic              missed;
    } result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] enrichment_gain;
        logic [TIME_W-1:0] miss_window;
    } cfg_t;

endpackage

FILE: rtl/core/injector_pulse_extender_unit.sv
// Injector pulse extender, one channel.
// Path from input accept to result accept: input register, then result register.
// Throughput: one item per cycle while m_tready is not held low; each item's state update
//   is one pass through the end-time multiply/add and miss compare between the two registers.
// Reset (aresetn low, synchronous): pulse and compare state cleared, output inactive,
//   enrichment_gain = 0, miss_window = 100, both stream stages emptied.
module injector_pulse_extender_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ipe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipe_pkg::CFG_DAT_W-1:0]     cfg_data,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // capture_time [15:0], now_count [31:16]
    input  logic [ipe_pkg::S_TDATA_W-1:0]     s_tdata,
    // func [0], edge_rising [1]
    input  logic [ipe_pkg::S_TUSER_W-1:0]     s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // injector_drive [0], end_time [16:1], missed [17], zero [23:18]
    output logic [ipe_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                         adv;
    logic                         item_valid;
    ipe_pkg::item_t               item;
    ipe_pkg::result_t             res;
    ipe_pkg::cfg_t                cfg;
    logic [ipe_pkg::GAIN_W-1:0]   gain_reg;
    logic [ipe_pkg::TIME_W-1:0]   miss_window_reg;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= ipe_pkg::GAIN_RST;
            miss_window_reg <= ipe_pkg::MISS_WINDOW_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ipe_pkg::CFG_IDX_GAIN: gain_reg        <= cfg_data[ipe_pkg::GAIN_W-1:0];
                ipe_pkg::CFG_IDX_MISS: miss_window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.enrichment_gain = gain_reg;
    assign cfg.miss_window     = miss_window_reg;

    ipe_in u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    ipe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && adv),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    ipe_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (item_valid),
        .res        (res),
        .adv        (adv),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/core/ipe_in.sv
module ipe_in (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // capture_time [15:0], now_count [31:16]
    input  logic [ipe_pkg::S_TDATA_W-1:0]      s_tdata,
    // func [0], edge_rising [1]
    input  logic [ipe_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               adv,
    output logic                               item_valid,
    output ipe_pkg::item_t                     item
);

    logic           valid_reg;
    ipe_pkg::item_t item_reg;

    // Stage is free when empty or when its item moves on this cycle
    assign s_tready   = !valid_reg || adv;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload unpack, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.func         <= s_tuser[0];
            item_reg.edge_rising  <= s_tuser[1];
            item_reg.capture_time <= s_tdata[15:0];
            item_reg.now_count    <= s_tdata[31:16];
        end
    end

endmodule

FILE: rtl/core/ipe_core.sv
module ipe_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ipe_pkg::item_t    item,
    input  ipe_pkg::cfg_t     cfg,
    output ipe_pkg::result_t  res
);

    logic                        pulse_on_reg, pulse_on_next;
    logic [ipe_pkg::TIME_W-1:0]  start_time_reg, start_time_next;
    logic [ipe_pkg::TIME_W-1:0]  end_compare_reg, end_compare_next;
    logic                        compare_armed_reg, compare_armed_next;
    logic                        drive_level_reg, drive_level_next;

    logic [ipe_pkg::TIME_W-1:0]  width;
    logic [ipe_pkg::PROD_W-1:0]  prod;
    logic [ipe_pkg::TIME_W-1:0]  end_val;
    logic [ipe_pkg::TIME_W-1:0]  diff;
    logic                        miss_hit;
    logic                        missed;

    // End time arithmetic, all modulo 2^16
    always_comb begin
        width    = item.capture_time - start_time_reg;
        prod     = ipe_pkg::PROD_W'(cfg.enrichment_gain)
                 * ipe_pkg::PROD_W'(width[ipe_pkg::TIME_W-1:ipe_pkg::WIDTH_SHIFT]);
        end_val  = item.capture_time + prod[ipe_pkg::TIME_W-1:0];
        diff     = end_val - item.now_count;
        miss_hit = (end_val == item.now_count)
                || (diff > (ipe_pkg::TIME_MAX - cfg.miss_window));
    end

    // Next state per item kind
    always_comb begin
        pulse_on_next      = pulse_on_reg;
        start_time_next    = start_time_reg;
        end_compare_next   = end_compare_reg;
        compare_armed_next = compare_armed_reg;
        drive_level_next   = drive_level_reg;
        missed             = 1'b0;
        if (item.func == ipe_pkg::FUNC_TICK) begin
            if (compare_armed_reg && (item.now_count == end_compare_reg)) begin
                drive_level_next   = 1'b0;
                compare_armed_next = 1'b0;
            end
        end else if (!pulse_on_reg && !item.edge_rising) begin
            // start edge
            drive_level_next   = 1'b1;
            compare_armed_next = 1'b0;
            start_time_next    = item.capture_time;
            pulse_on_next      = 1'b1;
        end else if (pulse_on_reg && item.edge_rising) begin
            // end edge: arm compare, or force off if already passed
            end_compare_next   = end_val;
            compare_armed_next = !miss_hit;
            pulse_on_next      = 1'b0;
            if (miss_hit) begin
                missed           = 1'b1;
                drive_level_next = 1'b0;
            end
        end
    end

    assign res.injector_drive = drive_level_next;
    assign res.end_time       = end_compare_next;
    assign res.missed         = missed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_on_reg      <= 1'b0;
            start_time_reg    <= '0;
            end_compare_reg   <= '0;
            compare_armed_reg <= 1'b0;
            drive_level_reg   <= 1'b0;
        end else if (fire) begin
            pulse_on_reg      <= pulse_on_next;
            start_time_reg    <= start_time_next;
            end_compare_reg   <= end_compare_next;
            compare_armed_reg <= compare_armed_next;
            drive_level_reg   <= drive_level_next;
        end
    end

    // An armed compare only exists after the end edge
    a_armed_not_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        compare_armed_reg |-> !pulse_on_reg)
        else $error("compare armed during pulse");

    // Armed compare implies the output is still active
    a_armed_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        compare_armed_reg |-> drive_level_reg)
        else $error("compare armed with output inactive");

    // During a pulse the output is active
    a_pulse_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_on_reg |-> drive_level_reg)
        else $error("pulse on with output inactive");

    // A missed end leaves the output off and disarmed
    a_missed_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && missed) |=> (!drive_level_reg && !compare_armed_reg))
        else $error("missed end did not force output off");

endmodule

FILE: rtl/core/ipe_out.sv
module ipe_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load_valid,
    input  ipe_pkg::result_t               res,
    output logic                           adv,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // injector_drive [0], end_time [16:1], missed [17], zero [23:18]
    output logic [ipe_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic             valid_reg;
    ipe_pkg::result_t res_reg;

    // Register takes a new item when empty or being drained
    assign adv      = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.missed, res_reg.end_time, res_reg.injector_drive};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && load_valid) begin
            res_reg <= res;
        end
    end

endmodule

FILE: sim/injector_pulse_extender_unit_test.sv
`timescale 1ns / 1ps

module injector_pulse_extender_unit_test;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [ipe_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hA5;
    // Edge polarity codes
    localparam logic EDGE_FALL = 1'b0;
    localparam logic EDGE_RISE = 1'b1;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES      = 8;

    // Expected injector level, end time and miss flag per accepted item
    class injector_scoreboard;
        logic [ipe_pkg::GAIN_W-1:0] gain;
        logic [ipe_pkg::TIME_W-1:0] window;
        bit                         pulse_on;
        bit                         armed;
        bit                         drive;
        logic [ipe_pkg::TIME_W-1:0] start_t;
        logic [ipe_pkg::TIME_W-1:0] end_cmp;
        ipe_pkg::result_t           pending_levels[$];
        int                         errors;

        function new();
            gain     = ipe_pkg::GAIN_RST;
            window   = ipe_pkg::MISS_WINDOW_RST;
            pulse_on = 1'b0;
            armed    = 1'b0;
            drive    = 1'b0;
            start_t  = '0;
            end_cmp  = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [ipe_pkg::CFG_IDX_W-1:0] idx,
                                logic [ipe_pkg::CFG_DAT_W-1:0] data);
            if (idx == ipe_pkg::CFG_IDX_GAIN) begin
                gain = data[ipe_pkg::GAIN_W-1:0];
            end else if (idx == ipe_pkg::CFG_IDX_MISS) begin
                window = data;
            end
        endfunction

        function void log_item(ipe_pkg::item_t it);
            ipe_pkg::result_t           r;
            logic [ipe_pkg::TIME_W-1:0] width;
            logic [ipe_pkg::TIME_W-1:0] end_v;
            logic [ipe_pkg::TIME_W-1:0] diff;
            logic [ipe_pkg::PROD_W-1:0] prod;
            r.missed = 1'b0;
            if (it.func == ipe_pkg::FUNC_TICK) begin
                // compare match drops the output
                if (armed && it.now_count == end_cmp) begin
                    drive = 1'b0;
                    armed = 1'b0;
                end
            end else if (!pulse_on && it.edge_rising == EDGE_FALL) begin
                // start of command pulse
                drive    = 1'b1;
                armed    = 1'b0;
                start_t  = it.capture_time;
                pulse_on = 1'b1;
            end else if (pulse_on && it.edge_rising == EDGE_RISE) begin
                // end of command pulse: stretch by gain * width / 128
                width   = it.capture_time - start_t;
                prod    = ipe_pkg::PROD_W'(gain)
                        * ipe_pkg::PROD_W'(width[ipe_pkg::TIME_W-1:ipe_pkg::WIDTH_SHIFT]);
                end_v   = it.capture_time + prod[ipe_pkg::TIME_W-1:0];
                diff    = end_v - it.now_count;
                end_cmp = end_v;
                armed   = 1'b1;
                if (end_v == it.now_count || diff > ipe_pkg::TIME_MAX - window) begin
                    r.missed = 1'b1;
                    drive    = 1'b0;
                    armed    = 1'b0;
                end
                pulse_on = 1'b0;
            end
            r.injector_drive = drive;
            r.end_time       = end_cmp;
            pending_levels.push_back(r);
        endfunction

        function void check_level(ipe_pkg::result_t got);
            ipe_pkg::result_t want;
            if (pending_levels.size() == 0) begin
                errors++;
                $error("result item arrived with nothing pending");
                return;
            end
            want = pending_levels.pop_front();
            if (got.injector_drive !== want.injector_drive) begin
                errors++;
                $error("injector_drive: expected %0d, got %0d",
                       want.injector_drive, got.injector_drive);
            end
            if (got.end_time !== want.end_time) begin
                errors++;
                $error("end_time: expected %0h, got %0h", want.end_time, got.end_time);
            end
            if (got.missed !== want.missed) begin
                errors++;
                $error("missed: expected %0d, got %0d", want.missed, got.missed);
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ipe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ipe_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ipe_pkg::S_TDATA_W-1:0] s_tdata;
    logic [ipe_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ipe_pkg::M_TDATA_W-1:0] m_tdata;

    injector_scoreboard sb;
    int                 sent = 0;
    int                 idle_cycles = 0;
    bit                 src_steady = 1'b0;
    bit                 sink_steady = 1'b0;

    injector_pulse_extender_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic ipe_pkg::item_t make_item(logic f, logic r,
                                                 logic [ipe_pkg::TIME_W-1:0] cap,
                                                 logic [ipe_pkg::TIME_W-1:0] now);
        ipe_pkg::item_t it;
        it.func         = f;
        it.edge_rising  = r;
        it.capture_time = cap;
        it.now_count    = now;
        return it;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Tick count aimed at the armed end time most of the time
    function automatic logic [ipe_pkg::TIME_W-1:0] tick_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return sb.end_cmp;
        else if (r < 7) return ipe_pkg::TIME_W'(sb.end_cmp + $urandom_range(0, 2) - 1);
        else return ipe_pkg::TIME_W'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input ipe_pkg::item_t it);
        int gap;
        gap = (src_steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.now_count, it.capture_time};
        s_tuser  <= {it.edge_rising, it.func};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic write_reg(input logic [ipe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipe_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending and wait for every pending result, plus pipeline slack
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One well-formed command pulse with ticks around it
    task automatic run_pulse();
        logic [ipe_pkg::TIME_W-1:0] t0;
        logic [ipe_pkg::TIME_W-1:0] t1;
        logic [ipe_pkg::TIME_W-1:0] width;
        logic [ipe_pkg::TIME_W-1:0] now;
        int                         r;
        int                         n;
        t0 = ipe_pkg::TIME_W'($urandom);
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, t0, ipe_pkg::TIME_W'($urandom)));
        n = $urandom_range(0, 3);
        repeat (n) send_item(make_item(ipe_pkg::FUNC_TICK, 1'($urandom),
                                       ipe_pkg::TIME_W'($urandom), tick_time()));
        r = $urandom_range(0, 99);
        if (r < 70) width = ipe_pkg::TIME_W'($urandom_range(0, 1500));
        else if (r < 90) width = ipe_pkg::TIME_W'($urandom_range(1500, 20000));
        else width = ipe_pkg::TIME_W'($urandom);
        t1 = t0 + width;
        // place the count around the end time so the miss window gets exercised
        r = $urandom_range(0, 99);
        if (r < 25) now = t1;
        else if (r < 65) now = ipe_pkg::TIME_W'(t1 + $urandom_range(0, 500));
        else if (r < 80) now = ipe_pkg::TIME_W'(t1 - $urandom_range(0, 500));
        else now = ipe_pkg::TIME_W'($urandom);
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, t1, now));
        n = $urandom_range(0, 4);
        repeat (n) send_item(make_item(ipe_pkg::FUNC_TICK, 1'($urandom),
                                       ipe_pkg::TIME_W'($urandom), tick_time()));
    endtask

    // Accepted items, results and register writes
    always @(posedge aclk) begin
        ipe_pkg::result_t seen;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                sb.log_item(make_item(s_tuser[0], s_tuser[1], s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                seen.injector_drive = m_tdata[0];
                seen.end_time       = m_tdata[16:1];
                seen.missed         = m_tdata[17];
                sb.check_level(seen);
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
            (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side backpressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 4) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        int                         p;
        int                         target;
        bit                         paused;
        logic [ipe_pkg::GAIN_W-1:0] g;
        logic [ipe_pkg::TIME_W-1:0] w;
        sb = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        paused    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset register values (gain 0, window 100)
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h0000));  // unarmed tick
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'hFFFF, 16'hFFFF));  // rise, idle
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h0000, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h1234, 16'h0000));  // fall while on
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_RISE, 16'hFFFF, 16'hFFFF));  // unused set
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'h8000, 16'h0000));  // arm at 8000
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h7FFF));
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h8000));  // match
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h8000));  // disarmed
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h1000, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'h2000, 16'h2000));  // end == now
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'hFFF0, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'h0010, 16'h0074));  // window edge
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h0000, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'h0010, 16'h0075));  // just outside
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h4000, 16'h0000));  // restart
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h0010));  // stale end
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'h4000, 16'hC000));  // arm at 4000

        // Max gain (upper data byte must be dropped), zero window, spare index
        settle();
        write_reg(ipe_pkg::CFG_IDX_GAIN, 16'h01FF);
        write_reg(ipe_pkg::CFG_IDX_MISS, 16'h0000);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'h4000));  // match
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h0000, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'hFFFF, 16'hFD00));  // full, equal
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_FALL, 16'h0000, 16'h0000));
        send_item(make_item(ipe_pkg::FUNC_EDGE, EDGE_RISE, 16'hFFFF, 16'hFD01));  // one behind
        send_item(make_item(ipe_pkg::FUNC_TICK, EDGE_FALL, 16'h0000, 16'hFD00));  // match

        // Random phases over several register settings
        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin
                    g = ipe_pkg::GAIN_W'($urandom_range(0, 255));
                    w = ipe_pkg::TIME_W'($urandom_range(0, 400));
                end
                1: begin
                    g = 8'hFF;
                    w = ipe_pkg::TIME_MAX;
                end
                2: begin
                    g = 8'h00;
                    w = 16'h0000;
                end
                default: begin
                    g = ipe_pkg::GAIN_W'($urandom_range(1, 255));
                    w = ipe_pkg::TIME_W'($urandom);
                end
            endcase
            write_reg(ipe_pkg::CFG_IDX_GAIN, {8'($urandom), g});
            write_reg(ipe_pkg::CFG_IDX_MISS, w);
            if (p == 2) write_reg(CFG_IDX_SPARE, ipe_pkg::CFG_DAT_W'($urandom));
            src_steady  = (p == 5);
            sink_steady = (p == 5) || (p == 6);
            target = sent + PHASE_ITEMS;
            while (sent < target) begin
                // hold off mid-phase until all results are back
                if (p == 3 && !paused && sent >= target - PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 80) begin
                    run_pulse();
                end else begin
                    send_item(make_item(1'($urandom), 1'($urandom),
                                        ipe_pkg::TIME_W'($urandom),
                                        ipe_pkg::TIME_W'($urandom)));
                end
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ipe_pkg.sv
rtl/core/ipe_in.sv
rtl/core/ipe_core.sv
rtl/core/ipe_out.sv
rtl/core/injector_pulse_extender_unit.sv
sim/injector_pulse_extender_unit_test.sv
